>>> hw/rtl/u8dec_pkg.sv
// Shared types, status codes and decode helpers for the UTF-8 sequence decoder.
package u8dec_pkg;

    // Status codes carried on the result channel.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_BAD_CONT   = 3'd2;
    localparam logic [2:0] ST_OVERLONG   = 3'd3;
    localparam logic [2:0] ST_BAD_LEAD   = 3'd4;

    localparam int unsigned CP_W = 31;

    // First stage: lead byte classified, continuation bytes checked.
    typedef struct packed {
        logic [2:0]  len;       // announced length, zero for a bad lead byte
        logic [2:0]  avail;     // saturated byte count
        logic [6:0]  lead_pay;  // payload bits of the lead byte
        logic [29:0] tail;      // low six bits of byte1..byte5, byte1 on top
        logic [4:0]  cont_ok;   // bit i set when byte i+1 matches 10xxxxxx
    } s1_t;

    // Second stage: status before the overlong check, value assembled.
    typedef struct packed {
        logic [2:0]      status;
        logic [2:0]      len;
        logic [CP_W-1:0] cp;
    } s2_t;

    // Sequence length announced by a lead byte; zero means a bad lead byte.
    function automatic logic [2:0] lead_len(input logic [7:0] lead);
        logic [2:0] n;
        begin
            n = 3'd0;
            if (lead[7] == 1'b0)              n = 3'd1;
            else if (lead[7:5] == 3'b110)     n = 3'd2;
            else if (lead[7:4] == 4'b1110)    n = 3'd3;
            else if (lead[7:3] == 5'b11110)   n = 3'd4;
            else if (lead[7:2] == 6'b111110)  n = 3'd5;
            else if (lead[7:1] == 7'b1111110) n = 3'd6;
            return n;
        end
    endfunction

    // Payload bits of the lead byte for a given length.
    function automatic logic [6:0] lead_payload(input logic [7:0] lead, input logic [2:0] n);
        logic [6:0] p;
        begin
            case (n)
                3'd1:    p = lead[6:0];
                3'd2:    p = {2'b00, lead[4:0]};
                3'd3:    p = {3'b000, lead[3:0]};
                3'd4:    p = {4'b0000, lead[2:0]};
                3'd5:    p = {5'b00000, lead[1:0]};
                3'd6:    p = {6'b000000, lead[0]};
                default: p = 7'd0;
            endcase
            return p;
        end
    endfunction

    // Smallest value that is not overlong for a sequence of three to six bytes; zero for other lengths.
    function automatic logic [CP_W-1:0] min_value(input logic [2:0] n);
        logic [CP_W-1:0] m;
        begin
            case (n)
                3'd3:    m = 31'h0000_0800;
                3'd4:    m = 31'h0001_0000;
                3'd5:    m = 31'h0020_0000;
                3'd6:    m = 31'h0400_0000;
                default: m = 31'h0000_0000;
            endcase
            return m;
        end
    endfunction

endpackage

>>> hw/rtl/u8dec_if.sv
// Valid/ready channel interfaces for byte windows and decoded characters.
interface u8dec_win_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [2:0] avail_count;

    modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, avail_count,
                    input ready);
    modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, avail_count,
                    output ready);
endinterface

interface u8dec_res_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic [2:0]  consumed;
    logic [2:0]  status;

    modport source (output valid, code_point, consumed, status, input ready);
    modport sink   (input valid, code_point, consumed, status, output ready);
endinterface

>>> hw/rtl/utf8_sequence_decoder.sv
// Top level: three-stage pipelined decoder of one legacy UTF-8 character per beat.
//
//   channel | modport | direction | payload
//   win     | sink    | in        | byte0..byte5, avail_count
//   res     | source  | out       | code_point, consumed, status
//
// A window passes the three register stages (classify, assemble, overlong
// check) on its way to its result; one beat is taken every cycle unless a
// stall on res has filled the stages. Reset clears only the stage valid
// bits. Each stage loads when it is empty or the stage after it moves, so
// a stall on res backs up through the stages without dropping or repeating a beat.
module utf8_sequence_decoder (
    input logic          clk,
    input logic          rst_n,
    u8dec_win_if.sink    win,
    u8dec_res_if.source  res
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    u8dec_pkg::s1_t s1_reg, s1_next;
    u8dec_pkg::s2_t s2_reg, s2_next;

    logic [30:0] cp_reg, cp_next;
    logic [2:0]  consumed_reg, consumed_next;
    logic [2:0]  status_reg, status_next;

    logic [4:0] needed;
    logic       good;

    // Stage enables: a stage moves when empty or when its successor moves.
    assign en3 = !v3_reg || res.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign win.ready = en1;

    // Stage one: lead byte length, count saturation, continuation checks.
    always_comb
    begin
        s1_next.len      = u8dec_pkg::lead_len(win.byte0);
        s1_next.avail    = (win.avail_count == 3'd7) ? 3'd6 : win.avail_count;
        s1_next.lead_pay = u8dec_pkg::lead_payload(win.byte0, s1_next.len);
        s1_next.tail     = {win.byte1[5:0], win.byte2[5:0], win.byte3[5:0],
                            win.byte4[5:0], win.byte5[5:0]};
        s1_next.cont_ok  = {win.byte5[7:6] == 2'b10, win.byte4[7:6] == 2'b10,
                            win.byte3[7:6] == 2'b10, win.byte2[7:6] == 2'b10,
                            win.byte1[7:6] == 2'b10};
    end

    // Stage two: status before the overlong check and the assembled value.
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            needed[i] = (3'(i + 1) < s1_reg.len);
        end
        good = &(s1_reg.cont_ok | ~needed);

        s2_next.len = s1_reg.len;
        s2_next.cp  = '0;
        if (s1_reg.avail == 3'd0)
        begin
            s2_next.status = u8dec_pkg::ST_INCOMPLETE;
        end
        else if (s1_reg.len == 3'd0)
        begin
            s2_next.status = u8dec_pkg::ST_BAD_LEAD;
        end
        else if (s1_reg.avail < s1_reg.len)
        begin
            s2_next.status = u8dec_pkg::ST_INCOMPLETE;
        end
        else if (!good)
        begin
            s2_next.status = u8dec_pkg::ST_BAD_CONT;
        end
        else
        begin
            s2_next.status = u8dec_pkg::ST_OK;
            case (s1_reg.len)
                3'd1:    s2_next.cp = 31'({s1_reg.lead_pay});
                3'd2:    s2_next.cp = 31'({s1_reg.lead_pay[4:0], s1_reg.tail[29:24]});
                3'd3:    s2_next.cp = 31'({s1_reg.lead_pay[3:0], s1_reg.tail[29:18]});
                3'd4:    s2_next.cp = 31'({s1_reg.lead_pay[2:0], s1_reg.tail[29:12]});
                3'd5:    s2_next.cp = 31'({s1_reg.lead_pay[1:0], s1_reg.tail[29:6]});
                3'd6:    s2_next.cp = {s1_reg.lead_pay[0], s1_reg.tail};
                default: s2_next.cp = '0;
            endcase
        end
    end

    // Stage three: overlong check for three- to six-byte forms.
    always_comb
    begin
        cp_next       = s2_reg.cp;
        status_next   = s2_reg.status;
        consumed_next = 3'd0;
        if (s2_reg.status == u8dec_pkg::ST_OK)
        begin
            if (s2_reg.len >= 3'd3 && s2_reg.cp < u8dec_pkg::min_value(s2_reg.len))
            begin
                status_next = u8dec_pkg::ST_OVERLONG;
            end
            else
            begin
                consumed_next = s2_reg.len;
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= win.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            cp_reg       <= cp_next;
            consumed_reg <= consumed_next;
            status_reg   <= status_next;
        end
    end

    // Result beat.
    assign res.valid      = v3_reg;
    assign res.code_point = cp_reg;
    assign res.consumed   = consumed_reg;
    assign res.status     = status_reg;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the legacy six-byte UTF-8 sequence decoder.
module tb_top;

    // Run limits, in clock cycles.
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 80;

    // Smallest values that are not overlong, by sequence length.
    localparam logic [30:0] FLOOR_3 = 31'h0000_0800;
    localparam logic [30:0] FLOOR_4 = 31'h0001_0000;
    localparam logic [30:0] FLOOR_5 = 31'h0020_0000;
    localparam logic [30:0] FLOOR_6 = 31'h0400_0000;

    typedef struct packed {
        logic [30:0] code_point;
        logic [2:0]  consumed;
        logic [2:0]  status;
    } char_result_t;

    logic clk;
    logic rst_n;

    u8dec_win_if win_ch ();
    u8dec_res_if res_ch ();

    utf8_sequence_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .win   (win_ch),
        .res   (res_ch)
    );

    char_result_t pending_chars[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           src_idle_en    = 1'b0;
    bit           sink_idle_en   = 1'b0;
    bit           hold_req       = 1'b0;

    // Clock with a period of two time units.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Decodes one window the way the block must; bytes holds byte0 in its low octet.
    function automatic char_result_t decode_window(input logic [47:0] bytes,
                                                   input logic [2:0] avail_in);
        char_result_t r;
        logic [7:0]   lead;
        logic [7:0]   lead_mask;
        logic [2:0]   avail;
        logic [2:0]   len;
        logic [30:0]  value;
        logic [30:0]  floor_value;
        bit           cont_good;
        int           k;
        r = '0;
        lead = bytes[7:0];
        avail = (avail_in == 3'd7) ? 3'd6 : avail_in;
        casez (lead)
            8'b0???????: len = 3'd1;
            8'b110?????: len = 3'd2;
            8'b1110????: len = 3'd3;
            8'b11110???: len = 3'd4;
            8'b111110??: len = 3'd5;
            8'b1111110?: len = 3'd6;
            default:     len = 3'd0;
        endcase
        if (avail == 3'd0)
            r.status = u8dec_pkg::ST_INCOMPLETE;
        else if (len == 3'd0)
            r.status = u8dec_pkg::ST_BAD_LEAD;
        else if (avail < len)
            r.status = u8dec_pkg::ST_INCOMPLETE;
        else
        begin
            // Payload bits of the lead shrink as the announced length grows.
            lead_mask = (len == 3'd1) ? 8'h7F : (8'hFF >> (len + 1));
            value = {23'd0, lead & lead_mask};
            cont_good = 1'b1;
            for (k = 1; k < 6; k++)
            begin
                if (k < len)
                begin
                    if (bytes[8*k+6 +: 2] != 2'b10)
                        cont_good = 1'b0;
                    value = {value[24:0], bytes[8*k +: 6]};
                end
            end
            case (len)
                3'd3:    floor_value = FLOOR_3;
                3'd4:    floor_value = FLOOR_4;
                3'd5:    floor_value = FLOOR_5;
                3'd6:    floor_value = FLOOR_6;
                default: floor_value = '0;
            endcase
            if (!cont_good)
                r.status = u8dec_pkg::ST_BAD_CONT;
            else if (value < floor_value)
            begin
                r.status = u8dec_pkg::ST_OVERLONG;
                r.code_point = value;
            end
            else
            begin
                r.status = u8dec_pkg::ST_OK;
                r.code_point = value;
                r.consumed = len;
            end
        end
        return r;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(0, 2);
    endfunction

    // Offers one window and waits until the block takes the beat.
    task automatic send_window(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic [7:0] b4, input logic [7:0] b5,
                               input logic [2:0] avail);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            win_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        win_ch.byte0       <= b0;
        win_ch.byte1       <= b1;
        win_ch.byte2       <= b2;
        win_ch.byte3       <= b3;
        win_ch.byte4       <= b4;
        win_ch.byte5       <= b5;
        win_ch.avail_count <= avail;
        win_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!win_ch.ready);
        pending_chars.push_back(decode_window({b5, b4, b3, b2, b1, b0}, avail));
    endtask

    // Builds a random window: mostly well-formed sequences, some broken, some noise.
    task automatic make_random_window(output logic [47:0] bytes, output logic [2:0] avail);
        int         kind;
        int         k;
        logic [2:0] len;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        bytes = 48'({$urandom, $urandom});
        if (kind < 15)
        begin
            avail = 3'($urandom_range(0, 7));
            return;
        end
        len = 3'($urandom_range(1, 6));
        lead = bytes[7:0];
        case (len)
            3'd1:    lead[7]   = 1'b0;
            3'd2:    lead[7:5] = 3'b110;
            3'd3:    lead[7:4] = 4'b1110;
            3'd4:    lead[7:3] = 5'b11110;
            3'd5:    lead[7:2] = 6'b111110;
            default: lead[7:1] = 7'b1111110;
        endcase
        // Clearing the lead payload now and then pushes values toward the overlong limits.
        if ($urandom_range(0, 4) == 0 && len > 3'd1)
            lead = lead & ~(8'hFF >> (len + 1));
        bytes[7:0] = lead;
        for (k = 1; k < 6; k++)
            if (k < len)
                bytes[8*k+6 +: 2] = 2'b10;
        // Break one continuation byte.
        if (kind < 25 && len > 3'd1)
        begin
            k = $urandom_range(1, len - 1);
            case ($urandom_range(0, 2))
                0:       bytes[8*k+6 +: 2] = 2'b00;
                1:       bytes[8*k+6 +: 2] = 2'b01;
                default: bytes[8*k+6 +: 2] = 2'b11;
            endcase
        end
        // Short windows, otherwise a count that covers the sequence.
        if (kind >= 25 && kind < 35)
            avail = (len > 3'd1) ? 3'($urandom_range(1, len - 1)) : 3'd0;
        else
            avail = 3'($urandom_range(len, 7));
    endtask

    task automatic send_random_windows(input int count);
        logic [47:0] w;
        logic [2:0]  a;
        repeat (count)
        begin
            make_random_window(w, a);
            send_window(w[7:0], w[15:8], w[23:16], w[31:24], w[39:32], w[47:40], a);
        end
    endtask

    // Single-byte characters at both ends of the range.
    task automatic test_ascii_extremes();
        send_window(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd1);
        send_window(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd6);
    endtask

    // An empty window is incomplete whatever it holds; a count of seven acts as six.
    task automatic test_counts();
        send_window(8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd0);
        send_window(8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 3'd7);
    endtask

    task automatic test_bad_lead();
        send_window(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6);
        send_window(8'hBF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6);
        send_window(8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6);
        send_window(8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7);
    endtask

    // Too few bytes for the announced length; the bytes present are not looked at.
    task automatic test_short_window();
        send_window(8'hE2, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 3'd2);
        send_window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd5);
    endtask

    task automatic test_bad_continuation();
        send_window(8'hC3, 8'h41, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6);
        send_window(8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'hC0, 3'd6);
    endtask

    // Overlong forms of three to six bytes, plus the first valid three-byte value.
    task automatic test_overlong();
        send_window(8'hE0, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3);
        send_window(8'hE0, 8'hA0, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3);
        send_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'h00, 8'h00, 3'd4);
        send_window(8'hF8, 8'h87, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd5);
        send_window(8'hFC, 8'h83, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6);
    endtask

    // Two-byte overlong leads pass unchecked.
    task automatic test_two_byte_overlong();
        send_window(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2);
        send_window(8'hC1, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2);
    endtask

    // Largest six-byte value, and bytes past the sequence that must be ignored.
    task automatic test_max_and_unused();
        send_window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6);
        send_window(8'hDF, 8'hBF, 8'hFF, 8'h00, 8'hC0, 8'h7F, 3'd6);
    endtask

    // Random traffic with idling on both sides.
    task automatic test_random_traffic(input int count);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        send_random_windows(count);
    endtask

    // Full-rate stretch with no idling at all.
    task automatic test_back_to_back(input int count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random_windows(count);
    endtask

    // The result side holds off for a long stretch while windows keep coming.
    task automatic test_output_backpressure(input int count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_req     = 1'b1;
        send_random_windows(count);
    endtask

    // Result side: checks each beat against the oldest prediction and drives ready.
    initial
    begin
        char_result_t want;
        int           stall_left;
        int           hold_left;
        stall_left = 0;
        hold_left  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing pending: cp %h consumed %0d status %0d",
                             $time, res_ch.code_point, res_ch.consumed, res_ch.status);
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (res_ch.code_point !== want.code_point)
                    begin
                        mismatch_count++;
                        $display("%0t: code_point expected %h actual %h",
                                 $time, want.code_point, res_ch.code_point);
                    end
                    if (res_ch.consumed !== want.consumed)
                    begin
                        mismatch_count++;
                        $display("%0t: consumed expected %0d actual %0d",
                                 $time, want.consumed, res_ch.consumed);
                    end
                    if (res_ch.status !== want.status)
                    begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, res_ch.status);
                    end
                end
            end
            // Pick ready for the next cycle.
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                res_ch.ready <= (stall_left == 0);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Main sequence: reset, directed tests, random tests, drain and verdict.
    initial
    begin
        rst_n              <= 1'b0;
        win_ch.valid       <= 1'b0;
        win_ch.byte0       <= 8'h00;
        win_ch.byte1       <= 8'h00;
        win_ch.byte2       <= 8'h00;
        win_ch.byte3       <= 8'h00;
        win_ch.byte4       <= 8'h00;
        win_ch.byte5       <= 8'h00;
        win_ch.avail_count <= 3'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_ascii_extremes();
        test_counts();
        test_bad_lead();
        test_short_window();
        test_bad_continuation();
        test_overlong();
        test_two_byte_overlong();
        test_max_and_unused();

        test_random_traffic(150);
        test_back_to_back(100);
        test_output_backpressure(40);
        test_random_traffic(110);

        win_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
